// File: src/sobv_pkg.sv
// Shared constants, types and lookup functions for the sky object billboard vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package sobv_pkg;

  localparam int CORNERS     = 6;
  localparam int COLOR_TYPES = 10;
  localparam int PIPE_DEPTH  = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int CNT_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_UP    = 3'd5;

  localparam logic [15:0] RADIUS_RST    = 16'd25600;
  localparam logic [47:0] SIZE_LIM_RST  = 48'd549760862208;
  localparam logic [15:0] ALPHA_LIM_RST = 16'd39194;
  localparam logic [31:0] MAG_RANGE_RST = 32'd50334208;

  // sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // obliquity rotation, Q1.14
  localparam logic signed [15:0] OBL_COS = 16'sd15032;
  localparam logic signed [15:0] OBL_SIN = 16'sd6517;

  typedef struct packed {
    logic signed [32:0] rs_x;
    logic signed [32:0] rs_y;
    logic signed [32:0] rs_z;
    logic signed [32:0] us_x;
    logic signed [32:0] us_y;
    logic signed [32:0] us_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         opacity;
  } attr_t;

  typedef struct packed {
    logic signed [18:0] ctr_x;
    logic signed [18:0] ctr_y;
    logic signed [18:0] ctr_z;
    attr_t              attr;
  } obj_t;

  function automatic logic [23:0] type_color(input logic [3:0] obj_type);
    logic [23:0] c;
    case (obj_type)
      4'd0:    c = {8'd230, 8'd230, 8'd205};
      4'd1:    c = {8'd230, 8'd218, 8'd179};
      4'd2:    c = {8'd230, 8'd77,  8'd77 };
      4'd3:    c = {8'd77,  8'd102, 8'd230};
      4'd4:    c = {8'd51,  8'd205, 8'd179};
      4'd5:    c = {8'd38,  8'd38,  8'd51 };
      4'd6:    c = {8'd230, 8'd128, 8'd154};
      4'd7:    c = {8'd179, 8'd192, 8'd230};
      4'd8:    c = {8'd230, 8'd205, 8'd154};
      4'd9:    c = {8'd179, 8'd205, 8'd243};
      default: c = {8'd128, 8'd128, 8'd128};
    endcase
    if (int'(obj_type) >= COLOR_TYPES) c = {8'd128, 8'd128, 8'd128};
    return c;
  endfunction

  // right-hand side of the quad: BR, TR, TR
  function automatic logic corner_u(input logic [CNT_W-1:0] c);
    logic u;
    case (c) inside
      3'd1, 3'd2, 3'd4: u = 1'b1;
      default:          u = 1'b0;
    endcase
    return u;
  endfunction

  // top side of the quad: TR, TR, TL
  function automatic logic corner_v(input logic [CNT_W-1:0] c);
    logic v;
    case (c) inside
      3'd2, 3'd4, 3'd5: v = 1'b1;
      default:          v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] p);
    logic signed [15:0] r;
    if (p > 20'sd32767)       r = 16'sh7FFF;
    else if (p < -20'sd32768) r = 16'sh8000;
    else                      r = p[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/sobv_sine.sv
// Four-stage pipelined fixed-point sine, turn-fraction angle in, Q1.14 out.
`timescale 1ns / 1ps
`default_nettype none
module sobv_sine (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        angle,
  output logic signed [15:0]      sine
);
  import sobv_pkg::*;

  logic [1:0]  q_a_r, q_b_r, q_c_r;
  logic [14:0] z_a_r, z_b_r, z_c_r;
  logic [14:0] z2_a_r, z2_b_r;
  logic [15:0] t2_b_r;
  logic [16:0] t4_c_r;
  logic signed [15:0] sine_r;

  logic [14:0] z;
  logic [29:0] zz;
  logic [27:0] pc;
  logic [13:0] t1;
  logic [30:0] pt;
  logic [16:0] t3;
  logic [31:0] ps;
  logic [15:0] s, sc;

  always_comb begin
    z  = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    zz = {15'd0, z} * {15'd0, z};
    pc = {15'd0, SIN_C} * {13'd0, z2_a_r};
    t1 = pc[27:14];
    pt = {15'd0, t2_b_r} * {16'd0, z2_b_r};
    t3 = pt[30:14];
    ps = ({15'd0, t4_c_r} * {17'd0, z_c_r}) + 32'd32768;
    s  = ps[31:16];
    sc = (s > 16'd16384) ? 16'd16384 : s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r  <= angle[15:14];
      z_a_r  <= z;
      z2_a_r <= zz[28:14];
      q_b_r  <= q_a_r;
      z_b_r  <= z_a_r;
      z2_b_r <= z2_a_r;
      t2_b_r <= SIN_B - {2'd0, t1};
      q_c_r  <= q_b_r;
      z_c_r  <= z_b_r;
      t4_c_r <= SIN_A - t3;
      sine_r <= q_c_r[1] ? -$signed(sc) : $signed(sc);
    end
  end

  assign sine = sine_r;
endmodule
`default_nettype wire

// File: src/sobv_geom.sv
// Position path: sines, equatorial to ecliptic rotation, radius scaling (8 stages).
`timescale 1ns / 1ps
`default_nettype none
module sobv_geom (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        ra_turns,
  input  wire logic [15:0]        dec_angle,
  input  wire logic [15:0]        radius,
  output logic signed [18:0]      ctr_x,
  output logic signed [18:0]      ctr_y,
  output logic signed [18:0]      ctr_z
);
  import sobv_pkg::*;

  logic signed [15:0] cr, sr, cdv, sdv;
  logic signed [15:0] ex_r, ey_r, ez_r, ex6_r, yecl_r, zecl_r;
  logic signed [32:0] px_r, py_r, pz_r;
  logic signed [18:0] cx_r, cy_r, cz_r;

  logic signed [31:0] mx, my, sy, sz;
  logic signed [16:0] rad_s;
  logic signed [32:0] rx, ry, rz;

  sobv_sine u_sin_cr  (.clk(clk), .en(en), .angle(ra_turns + 16'd16384),  .sine(cr));
  sobv_sine u_sin_sr  (.clk(clk), .en(en), .angle(ra_turns),              .sine(sr));
  sobv_sine u_sin_cd  (.clk(clk), .en(en), .angle(dec_angle + 16'd16384), .sine(cdv));
  sobv_sine u_sin_sd  (.clk(clk), .en(en), .angle(dec_angle),             .sine(sdv));

  always_comb begin
    mx    = 32'(cdv * cr) + 32'sd8192;
    my    = 32'(cdv * sr) + 32'sd8192;
    sy    = 32'(ey_r * OBL_COS) + 32'(ez_r * OBL_SIN) + 32'sd8192;
    sz    = 32'(ez_r * OBL_COS) - 32'(ey_r * OBL_SIN) + 32'sd8192;
    rad_s = $signed({1'b0, radius});
    rx    = px_r + 33'sd8192;
    ry    = py_r + 33'sd8192;
    rz    = pz_r + 33'sd8192;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r   <= mx[29:14];
      ey_r   <= my[29:14];
      ez_r   <= sdv;
      ex6_r  <= ex_r;
      yecl_r <= sy[29:14];
      zecl_r <= sz[29:14];
      px_r   <= ex6_r * rad_s;
      py_r   <= zecl_r * rad_s;   // y axis is ecliptic north
      pz_r   <= yecl_r * rad_s;
      cx_r   <= rx[32:14];
      cy_r   <= ry[32:14];
      cz_r   <= rz[32:14];
    end
  end

  assign ctr_x = cx_r;
  assign ctr_y = cy_r;
  assign ctr_z = cz_r;
endmodule
`default_nettype wire

// File: src/sobv_attr.sv
// Attribute path: clamped size, magnitude alpha ramp with pipelined divider, colour (8 stages).
`timescale 1ns / 1ps
`default_nettype none
module sobv_attr (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        angular_size,
  input  wire logic signed [15:0] magnitude,
  input  wire logic [3:0]         obj_type,
  input  wire logic [47:0]        size_limits,
  input  wire logic [15:0]        alpha_limits,
  input  wire logic [31:0]        magnitude_range,
  input  wire logic [47:0]        camera_right,
  input  wire logic [47:0]        camera_up,
  output sobv_pkg::attr_t         attr
);
  import sobv_pkg::*;

  typedef struct packed {
    logic [15:0] size;
    logic        le_b;
    logic        ge_f;
    logic [7:0]  ab;
    logic [7:0]  af;
    logic [23:0] rgb;
  } side_t;

  side_t              side_r [0:6];
  logic signed [25:0] num1_r;
  logic [15:0]        den1_r;
  logic [15:0]        den_r  [0:3];
  logic [24:0]        rem_r  [0:3];
  logic [7:0]         quo_r  [0:4];
  logic               neg_r  [0:4];
  logic [7:0]         alpha7_r;
  attr_t              attr_r;

  logic [15:0]        base, smin, smax;
  logic [32:0]        szp;
  logic [24:0]        sraw;
  logic [15:0]        sclamp;
  logic signed [15:0] mb, mf;
  logic signed [16:0] dm, dmf;
  logic signed [8:0]  da;
  logic signed [25:0] absn;
  logic [7:0]         qfin;
  logic [7:0]         alpha;
  side_t              side1;

  always_comb begin
    base  = size_limits[47:32];
    smin  = size_limits[31:16];
    smax  = size_limits[15:0];
    szp   = ({17'd0, angular_size} * {17'd0, base}) + 33'd128;
    sraw  = szp[32:8];
    if (sraw < {9'd0, smin})      sclamp = smin;
    else if (sraw > {9'd0, smax}) sclamp = smax;
    else                          sclamp = sraw[15:0];

    mb  = magnitude_range[31:16];
    mf  = magnitude_range[15:0];
    dm  = {magnitude[15], magnitude} - {mb[15], mb};
    dmf = {mf[15], mf} - {mb[15], mb};
    da  = $signed({1'b0, alpha_limits[7:0]}) - $signed({1'b0, alpha_limits[15:8]});

    side1.size = sclamp;
    side1.le_b = (magnitude <= mb);
    side1.ge_f = (magnitude >= mf);
    side1.ab   = alpha_limits[15:8];
    side1.af   = alpha_limits[7:0];
    side1.rgb  = type_color(obj_type);

    absn  = num1_r[25] ? -num1_r : num1_r;

    qfin = neg_r[4] ? (8'd0 - quo_r[4]) : quo_r[4];
    if (side_r[5].le_b)      alpha = side_r[5].ab;
    else if (side_r[5].ge_f) alpha = side_r[5].af;
    else                     alpha = side_r[5].ab + qfin;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side1;
      for (int k = 1; k < 7; k++) side_r[k] <= side_r[k-1];
      num1_r    <= dm * da;
      den1_r    <= dmf[15:0];
      // rounded quotient: (|num| + den/2) / den, always below 256 on the ramp
      rem_r[0]  <= absn[24:0] + {10'd0, den1_r[15:1]};
      den_r[0]  <= den1_r;
      quo_r[0]  <= 8'd0;
      neg_r[0]  <= num1_r[25];
      alpha7_r  <= alpha;
    end
  end

  // two quotient bits per stage
  for (genvar g = 0; g < 4; g++) begin : g_div
    logic [24:0] d_hi, d_lo, r_mid, r_out;
    logic        b_hi, b_lo;
    always_comb begin
      d_hi  = {9'd0, den_r[g]} << (7 - 2 * g);
      d_lo  = {9'd0, den_r[g]} << (6 - 2 * g);
      b_hi  = (rem_r[g] >= d_hi);
      r_mid = b_hi ? (rem_r[g] - d_hi) : rem_r[g];
      b_lo  = (r_mid >= d_lo);
      r_out = b_lo ? (r_mid - d_lo) : r_mid;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[g+1] <= quo_r[g] | ({6'd0, b_hi, b_lo} << (6 - 2 * g));
        neg_r[g+1] <= neg_r[g];
      end
    end
    if (g < 3) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g+1] <= r_out;
          den_r[g+1] <= den_r[g];
        end
      end
    end
  end

  logic signed [16:0] size_s;
  assign size_s = $signed({1'b0, side_r[6].size});

  always_ff @(posedge clk) begin
    if (en) begin
      attr_r.rs_x    <= size_s * $signed(camera_right[47:32]);
      attr_r.rs_y    <= size_s * $signed(camera_right[31:16]);
      attr_r.rs_z    <= size_s * $signed(camera_right[15:0]);
      attr_r.us_x    <= size_s * $signed(camera_up[47:32]);
      attr_r.us_y    <= size_s * $signed(camera_up[31:16]);
      attr_r.us_z    <= size_s * $signed(camera_up[15:0]);
      attr_r.red     <= side_r[6].rgb[23:16];
      attr_r.green   <= side_r[6].rgb[15:8];
      attr_r.blue    <= side_r[6].rgb[7:0];
      attr_r.opacity <= alpha7_r;
    end
  end

  assign attr = attr_r;
endmodule
`default_nettype wire

// File: src/sobv_emit.sv
// Corner emitter: holds one object and sends its six quad vertices through an output register.
`timescale 1ns / 1ps
`default_nettype none
module sobv_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               obj_valid,
  input  wire sobv_pkg::obj_t     obj,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic signed [15:0]      out_pos_z,
  output logic                    out_tex_u,
  output logic                    out_tex_v,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_opacity,
  output logic [2:0]              out_corner_index,
  output logic                    out_last
);
  import sobv_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORNERS - 1);

  obj_t             obj_r;
  logic             obj_v_r, obj_v_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load, last_load, cu, cv;

  logic signed [15:0] px_r, py_r, pz_r;
  logic               u_r, v_r, last_r;
  logic [7:0]         red_r, green_r, blue_r, op_r;
  logic [2:0]         ci_r;

  function automatic logic signed [15:0] coord(input logic signed [18:0] ctr,
                                               input logic signed [32:0] a,
                                               input logic signed [32:0] b,
                                               input logic u, input logic v);
    logic signed [33:0] ae, be, s;
    logic signed [19:0] p;
    ae = {a[32], a};
    be = {b[32], b};
    s  = (u ? ae : -ae) + (v ? be : -be) + 34'sd16384;
    p  = {ctr[18], ctr} + {s[33], s[33:15]};
    return sat16(p);
  endfunction

  always_comb begin
    load      = obj_v_r && (!out_valid_r || out_ready);
    last_load = load && (cnt_r == CNT_LAST);
    take      = !obj_v_r || last_load;
    obj_v_nxt = take ? obj_valid : obj_v_r;
    cnt_nxt   = last_load ? '0 : (load ? cnt_r + 1'b1 : cnt_r);
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    cu = corner_u(cnt_r);
    cv = corner_v(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_v_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      obj_v_r     <= obj_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (obj_valid && take) obj_r <= obj;
    if (load) begin
      px_r    <= coord(obj_r.ctr_x, obj_r.attr.rs_x, obj_r.attr.us_x, cu, cv);
      py_r    <= coord(obj_r.ctr_y, obj_r.attr.rs_y, obj_r.attr.us_y, cu, cv);
      pz_r    <= coord(obj_r.ctr_z, obj_r.attr.rs_z, obj_r.attr.us_z, cu, cv);
      u_r     <= cu;
      v_r     <= cv;
      red_r   <= obj_r.attr.red;
      green_r <= obj_r.attr.green;
      blue_r  <= obj_r.attr.blue;
      op_r    <= obj_r.attr.opacity;
      ci_r    <= cnt_r;
      last_r  <= (cnt_r == CNT_LAST);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = px_r;
  assign out_pos_y        = py_r;
  assign out_pos_z        = pz_r;
  assign out_tex_u        = u_r;
  assign out_tex_v        = v_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_opacity      = op_r;
  assign out_corner_index = ci_r;
  assign out_last         = last_r;
endmodule
`default_nettype wire

// File: src/sky_object_billboard_vertex_gen_top.sv
// Top level: config registers, shared pipeline valid chain, geometry/attribute paths, emitter.
//
// Usage:
//   in_* channel (valid/ready) takes one catalog object per request. Objects with
//   in_has_name low are consumed and produce nothing.
//   out_* channel (valid/ready) returns six quad vertices per present object in
//   corner order BL,BR,TR,BL,TR,TL, out_last set on the sixth.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
// Timing:
//   8 pipeline stages (sines, rotation, scaling, alpha divider) plus the emitter:
//   a taken request passes every stage, then the emitter's object and output registers.
//   Sustained rate is one vertex per cycle while out_ready is high, set by the
//   single vertex output port. Requests enter back to back while earlier objects
//   are still in the pipe, until its last stage holds an object not yet taken.
// Reset: synchronous, active low; clears all valid state and loads register defaults.
// Stall: when out_ready is low the emitter holds, the pipeline freezes once its
//   last stage is full, and in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module sky_object_billboard_vertex_gen_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [15:0]                    in_ra_turns,
  input  wire logic signed [15:0]             in_dec_angle,
  input  wire logic [15:0]                    in_angular_size,
  input  wire logic signed [15:0]             in_magnitude,
  input  wire logic [3:0]                     in_object_type,
  input  wire logic                           in_has_name,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  out_pos_x,
  output logic signed [15:0]                  out_pos_y,
  output logic signed [15:0]                  out_pos_z,
  output logic                                out_tex_u,
  output logic                                out_tex_v,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [7:0]                          out_opacity,
  output logic [2:0]                          out_corner_index,
  output logic                                out_last,
  input  wire logic                           cfg_we,
  input  wire logic [sobv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sobv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sobv_pkg::*;

  logic [15:0] sphere_radius_r;
  logic [47:0] size_limits_r;
  logic [15:0] alpha_limits_r;
  logic [31:0] magnitude_range_r;
  logic [47:0] camera_right_r;
  logic [47:0] camera_up_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  en, take;
  obj_t                  obj;
  attr_t                 attr;
  logic signed [18:0]    cx, cy, cz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_radius_r   <= RADIUS_RST;
      size_limits_r     <= SIZE_LIM_RST;
      alpha_limits_r    <= ALPHA_LIM_RST;
      magnitude_range_r <= MAG_RANGE_RST;
      camera_right_r    <= '0;
      camera_up_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:    sphere_radius_r   <= cfg_data[15:0];
        REG_SIZE_LIM:  size_limits_r     <= cfg_data;
        REG_ALPHA_LIM: alpha_limits_r    <= cfg_data[15:0];
        REG_MAG_RANGE: magnitude_range_r <= cfg_data[31:0];
        REG_CAM_RIGHT: camera_right_r    <= cfg_data;
        REG_CAM_UP:    camera_up_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances together; it only holds when the last stage cannot drain
  assign en       = !vld_r[PIPE_DEPTH-1] || take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid && in_has_name};
  end

  sobv_geom u_geom (
    .clk       (clk),
    .en        (en),
    .ra_turns  (in_ra_turns),
    .dec_angle (in_dec_angle),
    .radius    (sphere_radius_r),
    .ctr_x     (cx),
    .ctr_y     (cy),
    .ctr_z     (cz)
  );

  sobv_attr u_attr (
    .clk             (clk),
    .en              (en),
    .angular_size    (in_angular_size),
    .magnitude       (in_magnitude),
    .obj_type        (in_object_type),
    .size_limits     (size_limits_r),
    .alpha_limits    (alpha_limits_r),
    .magnitude_range (magnitude_range_r),
    .camera_right    (camera_right_r),
    .camera_up       (camera_up_r),
    .attr            (attr)
  );

  always_comb begin
    obj.ctr_x = cx;
    obj.ctr_y = cy;
    obj.ctr_z = cz;
    obj.attr  = attr;
  end

  sobv_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .obj_valid        (vld_r[PIPE_DEPTH-1]),
    .obj              (obj),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_opacity      (out_opacity),
    .out_corner_index (out_corner_index),
    .out_last         (out_last)
  );
endmodule
`default_nettype wire

// File: src/sobv_checker.sv
// Port-level checks on the vertex stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sobv_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_pos_x,
  input wire logic               out_tex_u,
  input wire logic               out_tex_v,
  input wire logic [2:0]         out_corner_index,
  input wire logic               out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_corner_index))
    else $error("stalled vertex changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_corner_index == 3'd5)))
    else $error("last flag does not match sixth corner");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_corner_index == $past(out_corner_index) + 3'd1))
    else $error("quad corners not sent back to back in order");

  a_uv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner_index == 3'd0 || out_corner_index == 3'd3) |->
      !out_tex_u && !out_tex_v)
    else $error("bottom-left corner has wrong texture coordinate");

endmodule

bind sky_object_billboard_vertex_gen_top sobv_checker u_sobv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pos_x        (out_pos_x),
  .out_tex_u        (out_tex_u),
  .out_tex_v        (out_tex_v),
  .out_corner_index (out_corner_index),
  .out_last         (out_last)
);
`default_nettype wire
